FILE: sv/tst_pkg.sv
package tst_pkg;

	localparam int MAX_ORDER_DEF = 48;
	localparam int FRAC_BITS_DEF = 28;

	localparam int ANGLE_W = 32;
	localparam int TAN_W   = 48;
	localparam int STAT_W  = 2;
	localparam int SUM_W   = 64;
	localparam int QDIV_STEPS = 96;

	localparam logic [31:0]       THR_RESET = 32'd268;
	localparam logic [SUM_W-1:0]  CAP       = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [TAN_W:0]    TAN_MAXP  = 49'h0_7FFF_FFFF_FFFF;
	localparam logic [TAN_W:0]    TAN_MAXN  = 49'h0_8000_0000_0000;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_COS_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SAT      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_CHK,
		ST_MUL,
		ST_CLAMP,
		ST_DIV,
		ST_ACC,
		ST_FIN,
		ST_QDIV
	} tst_state_t;

	typedef struct packed {
		logic                    done;
		logic                    sat;
		logic signed [TAN_W-1:0] tangent;
	} tst_qres_t;

endpackage

FILE: sv/tst_qdiv.sv
module tst_qdiv import tst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SUM_W-1:0] num,
	input  logic [SUM_W-1:0] den,
	input  logic             neg,
	output tst_qres_t        res
);

	logic             active_q;
	logic [6:0]       cnt_q;
	logic [SUM_W-1:0] sh_q;
	logic [SUM_W-1:0] r_q;
	logic [TAN_W:0]   q_q;
	logic [SUM_W-1:0] den_q;
	logic             neg_q;
	logic             done_q;
	logic             sat_q;
	logic [TAN_W-1:0] tan_q;

	logic [SUM_W-1:0] r_nx;
	logic [TAN_W:0]   q_nx;
	logic             over;
	logic             last;
	logic [TAN_W:0]   limit;
	logic             sat_nx;
	logic [TAN_W:0]   mag;

	always_comb begin
		r_nx = {r_q[SUM_W-2:0], sh_q[SUM_W-1]};
		q_nx = {q_q[TAN_W-1:0], 1'b0};
		if (r_nx >= den_q) begin
			r_nx    = r_nx - den_q;
			q_nx[0] = 1'b1;
		end
		over   = q_nx > TAN_MAXN;
		last   = over || (cnt_q == 7'(QDIV_STEPS - 1));
		limit  = neg_q ? TAN_MAXN : TAN_MAXP;
		sat_nx = over || (q_nx > limit);
		mag    = sat_nx ? limit : q_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
			end else if (active_q && last) begin
				active_q <= 1'b0;
				done_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cnt_q <= '0;
			sh_q  <= num;
			r_q   <= '0;
			q_q   <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (active_q) begin
			cnt_q <= cnt_q + 7'd1;
			sh_q  <= {sh_q[SUM_W-2:0], 1'b0};
			r_q   <= r_nx;
			q_q   <= q_nx;
			if (last) begin
				sat_q <= sat_nx;
				tan_q <= neg_q ? (TAN_W'(0) - mag[TAN_W-1:0]) : mag[TAN_W-1:0];
			end
		end
	end

	assign res.done    = done_q;
	assign res.sat     = sat_q;
	assign res.tangent = tan_q;

endmodule

FILE: sv/taylor_series_tangent_unit.sv
// Tangent of a Q3.28 angle as sine over cosine, both summed from Maclaurin series.
// Each term after the first sine term uses the shared 32x32 multiplier, a clamp
// and the term divider; tst_qdiv divides sine by cosine unless cosine is zero.
// One angle at a time: busy stays high throughout, done strobes for one cycle.
// The receiver cannot stall; each result is valid only in its done cycle.
// Reset clears the sequencer and loads the threshold register with its reset value.
module taylor_series_tangent_unit import tst_pkg::*; #(
	parameter int MAX_ORDER = MAX_ORDER_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [31:0]               term_threshold,
	output logic signed [TAN_W-1:0]   tangent,
	output logic [STAT_W-1:0]         status,
	output logic                      done
);

	localparam int N_W = $clog2(MAX_ORDER + 3);
	localparam int D_W = 2 * N_W;
	localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

	tst_state_t state_q, state_nx;

	logic [31:0]             thr_q;
	logic [ANGLE_W-1:0]      ax_q;
	logic                    negx_q;
	logic [SUM_W-1:0]        x2_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] s_q;
	logic [SUM_W-1:0]        term_q;
	logic                    is_cos_q;
	logic [N_W-1:0]          n_q;
	logic [D_W-1:0]          d_q;
	logic [127:0]            acc_q;
	logic [63:0]             pp_q;
	logic [1:0]              pp_off_q;
	logic [2:0]              mcnt_q;
	logic [SUM_W-1:0]        div_q;
	logic [D_W-1:0]          rem_q;
	logic [2:0]              dcnt_q;
	logic                    sat_q;
	logic signed [TAN_W-1:0] tan_q;
	logic [STAT_W-1:0]       stat_q;
	logic                    done_q;

	logic                    more;
	logic [63:0]             sq;
	logic [31:0]             a_sel;
	logic [31:0]             b_sel;
	logic [127:0]            pp_sh;
	logic [127:0]            shifted;
	logic [SUM_W-1:0]        dq_nx;
	logic [D_W-1:0]          rem_nx;
	logic [SUM_W-1:0]        t_val;
	logic signed [SUM_W-1:0] sum_raw;
	logic signed [SUM_W-1:0] sum_cl;
	logic                    sum_ov;
	logic signed [SUM_W-1:0] s_fin;
	logic [SUM_W-1:0]        as_mag;
	logic [SUM_W-1:0]        ac_mag;
	logic                    q_neg;
	logic                    qgo;
	tst_qres_t               qres;

	assign more = (n_q <= N_W'(MAX_ORDER)) && (term_q > {32'b0, thr_q});

	always_comb begin
		if (state_q == ST_SQR) begin
			a_sel = ax_q;
			b_sel = ax_q;
		end else begin
			a_sel = mcnt_q[0] ? term_q[63:32] : term_q[31:0];
			b_sel = mcnt_q[1] ? x2_q[63:32] : x2_q[31:0];
		end
		sq = a_sel * b_sel;
		unique case (pp_off_q)
			2'd0:    pp_sh = {64'b0, pp_q};
			2'd1:    pp_sh = {32'b0, pp_q, 32'b0};
			default: pp_sh = {pp_q, 64'b0};
		endcase
		shifted = acc_q >> FRAC_BITS;
	end

	always_comb begin
		logic [D_W:0] r2;
		dq_nx  = div_q;
		rem_nx = rem_q;
		for (int k = 0; k < 8; k++) begin
			r2    = {rem_nx, dq_nx[SUM_W-1]};
			dq_nx = {dq_nx[SUM_W-2:0], 1'b0};
			if (r2 >= {1'b0, d_q}) begin
				r2       = r2 - {1'b0, d_q};
				dq_nx[0] = 1'b1;
			end
			rem_nx = r2[D_W-1:0];
		end
	end

	always_comb begin
		t_val   = (n_q == N_W'(1)) ? {32'b0, ax_q} : div_q;
		sum_raw = n_q[1] ? (sum_q - signed'(t_val)) : (sum_q + signed'(t_val));
		sum_ov  = 1'b0;
		sum_cl  = sum_raw;
		if (sum_raw > signed'(CAP)) begin
			sum_cl = signed'(CAP);
			sum_ov = 1'b1;
		end else if (sum_raw < -signed'(CAP)) begin
			sum_cl = -signed'(CAP);
			sum_ov = 1'b1;
		end
		s_fin  = negx_q ? -s_q : s_q;
		as_mag = s_fin[SUM_W-1] ? unsigned'(-s_fin) : unsigned'(s_fin);
		ac_mag = sum_q[SUM_W-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
		q_neg  = s_fin[SUM_W-1] != sum_q[SUM_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		qgo      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_nx = ST_SQR;
			end
			ST_SQR:   state_nx = ST_CHK;
			ST_CHK: begin
				if (more) state_nx = (n_q == N_W'(1)) ? ST_ACC : ST_MUL;
				else if (is_cos_q) state_nx = ST_FIN;
			end
			ST_MUL: begin
				if (mcnt_q == 3'd4) state_nx = ST_CLAMP;
			end
			ST_CLAMP: state_nx = ST_DIV;
			ST_DIV: begin
				if (dcnt_q == 3'd7) state_nx = ST_ACC;
			end
			ST_ACC:   state_nx = ST_CHK;
			ST_FIN: begin
				if (sum_q == '0) begin
					state_nx = ST_IDLE;
				end else begin
					qgo      = 1'b1;
					state_nx = ST_QDIV;
				end
			end
			ST_QDIV: begin
				if (qres.done) state_nx = ST_IDLE;
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			done_q <= 1'b0;
		end else begin
			if (cfg_valid) thr_q <= term_threshold;
			done_q <= ((state_q == ST_FIN) && (sum_q == '0)) ||
				((state_q == ST_QDIV) && qres.done);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					negx_q <= angle[ANGLE_W-1];
					ax_q   <= angle[ANGLE_W-1] ? (ANGLE_W'(0) - unsigned'(angle))
						: unsigned'(angle);
					sat_q  <= 1'b0;
				end
			end
			ST_SQR: begin
				x2_q     <= sq >> FRAC_BITS;
				sum_q    <= '0;
				term_q   <= ONE;
				n_q      <= N_W'(1);
				is_cos_q <= 1'b0;
			end
			ST_CHK: begin
				if (more) begin
					acc_q  <= '0;
					mcnt_q <= '0;
					d_q    <= D_W'(n_q) * D_W'(n_q - N_W'(1));
				end else if (!is_cos_q) begin
					s_q      <= sum_q;
					sum_q    <= signed'(ONE);
					term_q   <= ONE;
					n_q      <= N_W'(2);
					is_cos_q <= 1'b1;
				end
			end
			ST_MUL: begin
				mcnt_q <= mcnt_q + 3'd1;
				if (mcnt_q != 3'd4) begin
					pp_q     <= sq;
					pp_off_q <= 2'(mcnt_q[0]) + 2'(mcnt_q[1]);
				end
				if (mcnt_q != 3'd0) acc_q <= acc_q + pp_sh;
			end
			ST_CLAMP: begin
				if ((|shifted[127:SUM_W]) || (shifted[SUM_W-1:0] > CAP)) begin
					div_q <= CAP;
					sat_q <= 1'b1;
				end else begin
					div_q <= shifted[SUM_W-1:0];
				end
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				div_q  <= dq_nx;
				rem_q  <= rem_nx;
				dcnt_q <= dcnt_q + 3'd1;
			end
			ST_ACC: begin
				sum_q  <= sum_cl;
				term_q <= t_val;
				n_q    <= n_q + N_W'(2);
				if (sum_ov) sat_q <= 1'b1;
			end
			ST_FIN: begin
				if (sum_q == '0) begin
					tan_q  <= '0;
					stat_q <= STAT_COS_ZERO;
				end
			end
			ST_QDIV: begin
				if (qres.done) begin
					tan_q  <= qres.tangent;
					stat_q <= (sat_q || qres.sat) ? STAT_SAT : STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	tst_qdiv u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (qgo),
		.num    (as_mag),
		.den    (ac_mag),
		.neg    (q_neg),
		.res    (qres)
	);

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign tangent   = tan_q;
	assign status    = stat_q;
	assign done      = done_q;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tst_pkg::*;

	localparam int ORDER = MAX_ORDER_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [63:0] ONE = 64'd1 << FRAC;
	localparam int PI_HALF = 421657428;
	localparam int PI_FULL = 843314857;

	typedef struct {
		logic signed [ANGLE_W-1:0] angle;
		int gap;
	} angle_item_t;

	typedef struct {
		logic signed [TAN_W-1:0] tangent;
		logic [STAT_W-1:0] status;
	} tan_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] term_threshold = '0;
	logic signed [TAN_W-1:0] tangent;
	logic [STAT_W-1:0] status;
	logic done;

	angle_item_t angle_pending[$];
	tan_result_t tan_expected[$];
	logic [31:0] thr_model = THR_RESET;
	logic taken = 1'b0;
	int wait_cnt = 0;
	int fails = 0;

	taylor_series_tangent_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.angle(angle),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.term_threshold(term_threshold),
		.tangent(tangent),
		.status(status),
		.done(done)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b,
			inout logic sat);
		logic [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		p = p >> FRAC;
		if (p > {64'b0, CAP}) begin
			sat = 1'b1;
			return CAP;
		end
		return p[63:0];
	endfunction

	function automatic longint sum_clamp(input longint v, inout logic sat);
		if (v > longint'(CAP)) begin
			sat = 1'b1;
			return longint'(CAP);
		end
		if (v < -longint'(CAP)) begin
			sat = 1'b1;
			return -longint'(CAP);
		end
		return v;
	endfunction

	function automatic longint series_sum(input int first_n, input logic [63:0] ax,
			input logic [63:0] x2, input logic [31:0] thr, inout logic sat);
		longint sum;
		logic [63:0] prev;
		logic [63:0] last;
		logic [63:0] t;
		int n;
		sum = (first_n == 1) ? 0 : longint'(ONE);
		prev = ONE;
		last = ONE;
		n = first_n;
		while (n <= ORDER && last > {32'b0, thr}) begin
			if (n == 1)
				t = (ax > CAP) ? CAP : ax;
			else
				t = fx_mul(prev, x2, sat) / 64'(n * (n - 1));
			if (((n >> 1) & 1) != 0)
				sum = sum_clamp(sum - longint'(t), sat);
			else
				sum = sum_clamp(sum + longint'(t), sat);
			prev = t;
			last = t;
			n += 2;
		end
		return sum;
	endfunction

	function automatic tan_result_t tan_predict(input logic [31:0] raw, input logic [31:0] thr);
		tan_result_t r;
		logic neg_x;
		logic neg;
		logic sat;
		logic [63:0] ax;
		logic [63:0] x2;
		logic [63:0] as_mag;
		logic [63:0] ac_mag;
		longint s;
		longint c;
		logic [127:0] q;
		logic [TAN_W:0] lim;
		logic [TAN_W:0] mag;
		sat = 1'b0;
		neg_x = raw[31];
		ax = neg_x ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
		x2 = fx_mul(ax, ax, sat);
		s = series_sum(1, ax, x2, thr, sat);
		c = series_sum(2, ax, x2, thr, sat);
		if (neg_x)
			s = -s;
		if (c == 0) begin
			r.tangent = '0;
			r.status = STAT_COS_ZERO;
			return r;
		end
		as_mag = (s < 0) ? 64'(-s) : 64'(s);
		ac_mag = (c < 0) ? 64'(-c) : 64'(c);
		neg = (s < 0) != (c < 0);
		q = {32'b0, as_mag, 32'b0} / {64'b0, ac_mag};
		lim = neg ? TAN_MAXN : TAN_MAXP;
		if (q > {79'b0, lim}) begin
			mag = lim;
			sat = 1'b1;
		end else begin
			mag = q[TAN_W:0];
		end
		r.tangent = neg ? -mag[TAN_W-1:0] : mag[TAN_W-1:0];
		r.status = sat ? STAT_SAT : STAT_OK;
		return r;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
			end else if (angle_pending.size() != 0) begin
				if (wait_cnt < angle_pending[0].gap) begin
					start <= 1'b0;
					wait_cnt <= wait_cnt + 1;
				end else begin
					start <= 1'b1;
					angle <= angle_pending[0].angle;
					void'(angle_pending.pop_front());
					wait_cnt <= 0;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tan_result_t got;
		tan_result_t want;
		if (arst_n) begin
			taken <= start && !busy;
			if (cfg_valid && cfg_ready)
				thr_model = term_threshold;
			if (start && !busy)
				tan_expected.push_back(tan_predict(angle, thr_model));
			if (done) begin
				got.tangent = tangent;
				got.status = status;
				if (tan_expected.size() == 0) begin
					$error("unexpected result: tangent %0d status %0d", got.tangent, got.status);
					fails++;
				end else begin
					want = tan_expected.pop_front();
					if (got.tangent !== want.tangent) begin
						$error("tangent: expected %0d, actual %0d", want.tangent, got.tangent);
						fails++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fails++;
					end
				end
			end
		end
	end

	task automatic thr_write(input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		term_threshold <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic angle_push(input logic [31:0] value, input bit no_gaps);
		angle_item_t it;
		it.angle = value;
		it.gap = no_gaps ? 0 : $urandom_range(0, 11);
		angle_pending.push_back(it);
	endtask

	function automatic logic [31:0] angle_random();
		int k;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4: return $urandom_range(0, 1 << 20) - (1 << 19);
			5, 6, 7: begin
				k = $urandom_range(0, 4) - 2;
				return PI_HALF + k * PI_FULL + $urandom_range(0, 4000) - 2000;
			end
			default: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000 + 32'h1000_0000
				* ($urandom_range(0, 14) - 7);
		endcase
	endfunction

	task automatic drain();
		while (angle_pending.size() != 0 || start || tan_expected.size() != 0 || busy)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] thr_list[8];
		logic [31:0] directed[$];
		bit no_gaps;
		thr_list = '{32'd0, 32'hFFFF_FFFF, 32'd268, 32'd1 << FRAC, (32'd1 << FRAC) - 32'd1,
			32'd1, 32'd0, 32'd0};
		thr_list[6] = $urandom_range(0, 1 << 20);
		thr_list[7] = $urandom;
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h1000_0000, 32'hF000_0000, 32'(PI_HALF), 32'(-PI_HALF), 32'(PI_HALF + 1),
			32'(PI_HALF - 1), 32'(PI_HALF + 10), 32'(PI_HALF - 10), 32'(PI_FULL),
			32'd210828714, 32'(3 * PI_HALF), 32'(-3 * PI_HALF), 32'h5555_5555,
			32'hAAAA_AAAA, 32'(5 * PI_HALF), 32'(-5 * PI_HALF)};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			angle_push(directed[i], 1'b0);
		repeat (100)
			angle_push(angle_random(), 1'b0);
		drain();
		foreach (thr_list[p]) begin
			thr_write(thr_list[p]);
			no_gaps = ($urandom_range(0, 2) == 0);
			foreach (directed[i])
				if (i < 6)
					angle_push(directed[i], no_gaps);
			repeat (100)
				angle_push(angle_random(), no_gaps);
			drain();
		end
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
sv/tst_pkg.sv
sv/tst_qdiv.sv
sv/taylor_series_tangent_unit.sv
dv/tb_top.sv
